/* rtl/assert_macros.svh */
// Assertion helpers used by light_sensor_autorange_lux.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LSAL_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("lsal: invariant violated");

// When cond holds, expr must hold in the next cycle.
`define LSAL_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("lsal: sequence violated");

`endif

/* rtl/lsal_pkg.sv */
package lsal_pkg;

   // one input beat
   typedef struct packed {
      logic [15:0] full_count;
      logic [15:0] ir_raw;
      logic [31:0] now_ms;
   } req_type;

   // one result beat
   typedef struct packed {
      logic [31:0] micro_lux;
      logic [15:0] full_average;
      logic [15:0] ir_average;
      logic [1:0]  gain_code;
      logic [2:0]  time_code;
      logic        range_changed;
   } rsp_type;

   // alternation mode codes
   typedef enum logic [1:0] {
      MODE_NONE = 2'd0,
      MODE_GAIN = 2'd1,
      MODE_TIME = 2'd2,
      MODE_BOTH = 2'd3
   } mode_type;

   // register indexes
   localparam logic [2:0] CSR_EXTREME_LEVEL    = 3'd0;
   localparam logic [2:0] CSR_SATURATION_LEVEL = 3'd1;
   localparam logic [2:0] CSR_WINDOW_HIGH      = 3'd2;
   localparam logic [2:0] CSR_WINDOW_LOW       = 3'd3;
   localparam logic [2:0] CSR_ADJUST_INTERVAL  = 3'd4;

   localparam logic [1:0]  GAIN_RESET = 2'd1;
   localparam logic [2:0]  TIME_RESET = 2'd2;
   localparam logic [2:0]  TIME_MAX   = 3'd5;
   localparam logic [1:0]  GAIN_MAX   = 2'd3;
   localparam logic [15:0] INVALID_AVG = 16'hFFFF;

   // 408e6 scale: 408 lux factor times 1e6 micro units
   localparam logic [28:0] LUX_SCALE = 29'd408000000;

   localparam int LUX_Q_W = 32;
   localparam int DEN1_W  = 26;
   localparam int DEN_W   = 40;
   localparam int NUM_W   = 61;

   function automatic logic [13:0] gain_factor(input logic [1:0] g);
      logic [13:0] f;
      case (g)
         2'd0: f = 14'd1;
         2'd1: f = 14'd25;
         2'd2: f = 14'd428;
         2'd3: f = 14'd9876;
         default: f = 14'd1;
      endcase
      return f;
   endfunction

   // integration time in ms for a time code
   function automatic logic [9:0] time_factor(input logic [2:0] t);
      return 10'(({7'd0, t} + 10'd1) * 10'd100);
   endfunction

   function automatic logic [1:0] extreme_gain_step(input logic [1:0] g);
      return (g == 2'd3) ? 2'd1 : 2'd0;
   endfunction

   function automatic logic [2:0] extreme_time_step(input logic [2:0] t);
      logic [2:0] r;
      case (t)
         3'd4: r = 3'd1;
         3'd5: r = 3'd2;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/light_sensor_autorange_lux.sv */
// Light-sensor auto-range and lux engine. One sample beat (full, infrared,
// timestamp) yields one result beat. The sample goes into a moving-average
// window held in a small RAM with running sums; both averages come out of a
// bit-serial divider, then two registered multiply stages form numerator
// and denominator, and a bit-serial divider yields micro-lux (skipped when
// the value saturates or an average is invalid). Auto-range stepping is
// done at accept and reports the new gain/time codes; lux uses the codes in
// force before the step. A new sample is taken only after the last one's
// result has moved to the output register, even while that result still
// waits there. The window RAM needs no clearing pass: only written entries
// are ever used.
`include "assert_macros.svh"

module light_sensor_autorange_lux #(
   parameter int WINDOW_DEPTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lsal_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lsal_pkg::rsp_type    rsp_data,
   input  logic                 csr_write_en,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_wdata
);

   localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W  = 16 + $clog2(WINDOW_DEPTH);
   localparam int ITER_W = 6;
   localparam int DEN_W  = lsal_pkg::DEN_W;
   localparam int NUM_W  = lsal_pkg::NUM_W;
   localparam int Q_W    = lsal_pkg::LUX_Q_W;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_AVG, S_MUL1, S_MUL2, S_CHK, S_DIV, S_OUT
   } state_type;

   state_type state_ff;

   // configuration
   logic [15:0] extreme_ff, saturation_ff, window_high_ff, window_low_ff;
   logic [31:0] interval_ff;

   // range state
   logic [1:0]  gain_ff;
   logic [2:0]  time_ff;
   logic [15:0] prev_full_ff;
   lsal_pkg::mode_type mode_ff;
   logic [31:0] last_change_ff;

   // window state
   logic [SLOT_W-1:0] slot_ff;
   logic [CNT_W-1:0]  fill_ff;
   logic [SUM_W-1:0]  fsum_ff, isum_ff;

   // per-item work registers
   lsal_pkg::req_type req_ff;
   logic [1:0]  g_old_ff;
   logic [2:0]  t_old_ff;
   logic        changed_ff;
   logic [CNT_W-1:0] count_ff;
   logic [SUM_W-1:0] fq_ff, iq_ff;
   logic [CNT_W-1:0] frem_ff, irem_ff;
   logic [ITER_W-1:0] iter_ff;
   logic        invalid_ff;
   logic [31:0] d2_ff;
   logic [lsal_pkg::DEN1_W-1:0] den1_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff, lrem_ff;
   logic [Q_W-1:0]   lq_ff;
   logic [31:0] lux_ff;
   logic        rsp_valid_ff;
   lsal_pkg::rsp_type rsp_ff;

   logic [31:0] ram_rdata;

   // auto-range rule on the incoming beat
   logic        elapsed;
   lsal_pkg::mode_type mode_in;
   logic        gain_on, time_on;
   logic [1:0]  gain_in;
   logic [2:0]  time_in;
   logic        changed_in;

   always_comb begin
      elapsed = (req_data.now_ms - last_change_ff) >= interval_ff;
      if (req_data.full_count == prev_full_ff) begin
         mode_in = (mode_ff == lsal_pkg::MODE_GAIN) ? lsal_pkg::MODE_TIME
                                                    : lsal_pkg::MODE_GAIN;
      end else begin
         mode_in = lsal_pkg::MODE_BOTH;
      end
      gain_on = (mode_in == lsal_pkg::MODE_GAIN) || (mode_in == lsal_pkg::MODE_BOTH);
      time_on = (mode_in == lsal_pkg::MODE_TIME) || (mode_in == lsal_pkg::MODE_BOTH);
      gain_in = gain_ff;
      time_in = time_ff;
      if (req_data.full_count > extreme_ff) begin
         if (gain_on && gain_ff != 2'd0) gain_in = lsal_pkg::extreme_gain_step(gain_ff);
         if (time_on && time_ff != 3'd0) time_in = lsal_pkg::extreme_time_step(time_ff);
      end
      if (req_data.full_count > saturation_ff && req_data.full_count <= extreme_ff) begin
         if (gain_on) begin
            if (gain_ff != 2'd0) gain_in = gain_ff - 2'd1;
            if (time_ff != 3'd0) time_in = time_ff - 3'd1;
         end
      end else if (req_data.full_count > window_high_ff) begin
         if (time_ff != 3'd0) time_in = time_ff - 3'd1;
         else if (gain_ff != 2'd0) gain_in = gain_ff - 2'd1;
      end else if (req_data.full_count < window_low_ff) begin
         if (time_ff < lsal_pkg::TIME_MAX) time_in = time_ff + 3'd1;
         else if (gain_ff < lsal_pkg::GAIN_MAX) gain_in = gain_ff + 2'd1;
      end
      if (!elapsed) begin
         gain_in = gain_ff;
         time_in = time_ff;
      end
      changed_in = (gain_in != gain_ff) || (time_in != time_ff);
   end

   // running sums: add new sample, drop the one it overwrites
   logic              window_full;
   logic [SUM_W-1:0]  fsum_in, isum_in;
   logic [CNT_W-1:0]  fill_in;
   logic [SLOT_W-1:0] slot_in;

   always_comb begin
      window_full = (fill_ff == CNT_W'(WINDOW_DEPTH));
      fsum_in = fsum_ff + SUM_W'(req_ff.full_count)
                - (window_full ? SUM_W'(ram_rdata[31:16]) : SUM_W'(0));
      isum_in = isum_ff + SUM_W'(req_ff.ir_raw)
                - (window_full ? SUM_W'(ram_rdata[15:0]) : SUM_W'(0));
      fill_in = window_full ? fill_ff : fill_ff + CNT_W'(1);
      slot_in = (slot_ff == SLOT_W'(WINDOW_DEPTH - 1)) ? SLOT_W'(0) : slot_ff + SLOT_W'(1);
   end

   // restoring divide steps for the averages
   logic [CNT_W:0]   ftrial, itrial;
   logic             fge, ige;
   logic [CNT_W-1:0] frem_in, irem_in;

   always_comb begin
      ftrial  = {frem_ff, fq_ff[SUM_W-1]};
      itrial  = {irem_ff, iq_ff[SUM_W-1]};
      fge     = ftrial >= {1'b0, count_ff};
      ige     = itrial >= {1'b0, count_ff};
      frem_in = fge ? CNT_W'(ftrial - {1'b0, count_ff}) : ftrial[CNT_W-1:0];
      irem_in = ige ? CNT_W'(itrial - {1'b0, count_ff}) : itrial[CNT_W-1:0];
   end

   // restoring divide step for lux
   logic [DEN_W:0]   ltrial;
   logic             lge;
   logic [DEN_W-1:0] lrem_in;
   logic [DEN_W-1:0] num_hi;

   always_comb begin
      ltrial  = {lrem_ff, lq_ff[Q_W-1]};
      lge     = ltrial >= {1'b0, den_ff};
      lrem_in = lge ? DEN_W'(ltrial - {1'b0, den_ff}) : ltrial[DEN_W-1:0];
      num_hi  = DEN_W'(num_ff[NUM_W-1:Q_W]);
   end

   logic [15:0] favg, iavg, dabs;
   assign favg = fq_ff[15:0];
   assign iavg = iq_ff[15:0];
   assign dabs = (favg >= iavg) ? (favg - iavg) : (iavg - favg);

   lsal_ram #(
      .WIDTH(32),
      .DEPTH(WINDOW_DEPTH)
   ) u_window (
      .clock      (clock),
      .write_en   (state_ff == S_READ),
      .write_addr (slot_ff),
      .write_data ({req_ff.full_count, req_ff.ir_raw}),
      .read_addr  (slot_ff),
      .read_data  (ram_rdata)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         rsp_valid_ff   <= 1'b0;
         extreme_ff     <= 16'd65000;
         saturation_ff  <= 16'd60000;
         window_high_ff <= 16'd30000;
         window_low_ff  <= 16'd20000;
         interval_ff    <= 32'd1000;
         gain_ff        <= lsal_pkg::GAIN_RESET;
         time_ff        <= lsal_pkg::TIME_RESET;
         prev_full_ff   <= 16'd0;
         mode_ff        <= lsal_pkg::MODE_NONE;
         last_change_ff <= 32'd0;
         slot_ff        <= '0;
         fill_ff        <= '0;
         fsum_ff        <= '0;
         isum_ff        <= '0;
      end else begin
         // register writes
         if (csr_write_en) begin
            case (csr_index)
               lsal_pkg::CSR_EXTREME_LEVEL:    extreme_ff     <= csr_wdata[15:0];
               lsal_pkg::CSR_SATURATION_LEVEL: saturation_ff  <= csr_wdata[15:0];
               lsal_pkg::CSR_WINDOW_HIGH:      window_high_ff <= csr_wdata[15:0];
               lsal_pkg::CSR_WINDOW_LOW:       window_low_ff  <= csr_wdata[15:0];
               lsal_pkg::CSR_ADJUST_INTERVAL:  interval_ff    <= csr_wdata;
               default: ;
            endcase
         end

         // S_OUT reloads the output register itself
         if (rsp_valid_ff && rsp_ready && state_ff != S_OUT) rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff     <= req_data;
                  g_old_ff   <= gain_ff;
                  t_old_ff   <= time_ff;
                  gain_ff    <= gain_in;
                  time_ff    <= time_in;
                  changed_ff <= changed_in;
                  if (elapsed) begin
                     mode_ff      <= mode_in;
                     prev_full_ff <= req_data.full_count;
                  end
                  if (changed_in) last_change_ff <= req_data.now_ms;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               fsum_ff  <= fsum_in;
               isum_ff  <= isum_in;
               fill_ff  <= fill_in;
               slot_ff  <= slot_in;
               count_ff <= fill_in;
               fq_ff    <= fsum_in;
               iq_ff    <= isum_in;
               frem_ff  <= '0;
               irem_ff  <= '0;
               iter_ff  <= ITER_W'(SUM_W - 1);
               state_ff <= S_AVG;
            end
            S_AVG: begin
               fq_ff   <= {fq_ff[SUM_W-2:0], fge};
               iq_ff   <= {iq_ff[SUM_W-2:0], ige};
               frem_ff <= frem_in;
               irem_ff <= irem_in;
               iter_ff <= iter_ff - ITER_W'(1);
               if (iter_ff == '0) state_ff <= S_MUL1;
            end
            S_MUL1: begin
               invalid_ff <= (favg == lsal_pkg::INVALID_AVG) ||
                             (iavg == lsal_pkg::INVALID_AVG) || (favg == 16'd0);
               d2_ff      <= {16'd0, dabs} * {16'd0, dabs};
               den1_ff    <= {10'd0, favg} * {16'd0, lsal_pkg::time_factor(t_old_ff)};
               state_ff   <= S_MUL2;
            end
            S_MUL2: begin
               num_ff   <= {29'd0, d2_ff} * {32'd0, lsal_pkg::LUX_SCALE};
               den_ff   <= {14'd0, den1_ff} * {26'd0, lsal_pkg::gain_factor(g_old_ff)};
               state_ff <= S_CHK;
            end
            S_CHK: begin
               if (invalid_ff) begin
                  lux_ff   <= 32'd0;
                  state_ff <= S_OUT;
               end else if (num_hi >= den_ff) begin
                  lux_ff   <= 32'hFFFF_FFFF;
                  state_ff <= S_OUT;
               end else begin
                  lrem_ff  <= num_hi;
                  lq_ff    <= num_ff[Q_W-1:0];
                  iter_ff  <= ITER_W'(Q_W - 1);
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               lq_ff   <= {lq_ff[Q_W-2:0], lge};
               lrem_ff <= lrem_in;
               iter_ff <= iter_ff - ITER_W'(1);
               if (iter_ff == '0) begin
                  lux_ff   <= {lq_ff[Q_W-2:0], lge};
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.micro_lux     <= lux_ff;
                  rsp_ff.full_average  <= favg;
                  rsp_ff.ir_average    <= iavg;
                  rsp_ff.gain_code     <= gain_ff;
                  rsp_ff.time_code     <= time_ff;
                  rsp_ff.range_changed <= changed_ff;
                  rsp_valid_ff         <= 1'b1;
                  state_ff             <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `LSAL_ASSERT(a_fill_bound, fill_ff <= CNT_W'(WINDOW_DEPTH))
   `LSAL_ASSERT(a_time_bound, time_ff <= lsal_pkg::TIME_MAX)
   `LSAL_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready)

endmodule

/* rtl/lsal_ram.sv */
module lsal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  write_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] write_addr,
   input  logic [WIDTH-1:0]                      write_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] read_addr,
   output logic [WIDTH-1:0]                      read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data <= mem_ff[read_addr];
   end

endmodule
